// ===== rtl/core/vmbp_pkg.sv =====
package vmbp_pkg;

  // Transaction kinds on the input channel
  typedef enum logic [3:0] {
    KIND_SET_ADDR  = 4'd0,
    KIND_VRAM_RD   = 4'd1,
    KIND_VRAM_WR   = 4'd2,
    KIND_SET_MOD   = 4'd3,
    KIND_MOD_RD    = 4'd4,
    KIND_PAL_RD    = 4'd5,
    KIND_PAL_BRD   = 4'd6,
    KIND_PAL_WR    = 4'd7,
    KIND_PAL_BWR   = 4'd8,
    KIND_BANK      = 4'd9,
    KIND_SHADOW    = 4'd10,
    KIND_LOOKUP    = 4'd11
  } kind_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;  // capture the accepted transaction
    logic exec;   // commit writes and load the result register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_stall;  // result register full and not being taken
  } dp_sts_t;

  localparam int unsigned ADDR_W    = 13;
  localparam int unsigned DATA_W    = 16;
  localparam int unsigned COLOR_W   = 8;
  localparam int unsigned HALF_MASK = 15;  // pointer bits that step; bit 15 is held

  localparam logic [14:0] SCALE_MUL = 15'd259;
  localparam logic [14:0] SCALE_ADD = 15'd33;

  // 6-bit color level to 8-bit: (v*259+33)>>6
  function automatic logic [7:0] scale6(input logic [5:0] v);
    logic [14:0] p;
    begin
      p = 15'(v) * SCALE_MUL + SCALE_ADD;
      return p[13:6];
    end
  endfunction

endpackage

// ===== rtl/core/video_memory_bus_port_unit.sv =====
// Channel  Handshake              Payload
// in       in_valid / in_ready    in_kind[3:0], in_address[12:0], in_write_data[15:0]
// out      out_valid / out_ready  out_read_data[15:0], out_red, out_green, out_blue [7:0]
//
// Each transaction passes accept, RAM read and execute; the registered-read
// port of the video and palette RAMs calls for the RAM read step.
// One transaction at a time; one result per transaction, in order.
// Reset (rst_n low, synchronous) clears pointer, modulo, bank, shadow and controller.
// The result register lets the next transaction be accepted while a result waits;
// a new result holds in the execute cycle until the register is free.
module video_memory_bus_port_unit
  import vmbp_pkg::*;
#(
  parameter int unsigned VRAM_WORDS         = 34816,
  parameter int unsigned PALETTE_BANK_WORDS = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [3:0]          in_kind,
  input  logic [ADDR_W-1:0]   in_address,
  input  logic [DATA_W-1:0]   in_write_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [DATA_W-1:0]   out_read_data,
  output logic [COLOR_W-1:0]  out_red,
  output logic [COLOR_W-1:0]  out_green,
  output logic [COLOR_W-1:0]  out_blue
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  vmbp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  vmbp_datapath #(
    .VRAM_WORDS         (VRAM_WORDS),
    .PALETTE_BANK_WORDS (PALETTE_BANK_WORDS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_kind       (in_kind),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_read_data (out_read_data),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue)
  );

endmodule

// ===== rtl/core/vmbp_ram.sv =====
module vmbp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/core/vmbp_ctrl.sv =====
module vmbp_ctrl
  import vmbp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (!sts.out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready  = 1'b0;
    cmd.latch = 1'b0;
    cmd.exec  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      ST_READ: ;
      ST_EXEC: cmd.exec = !sts.out_stall;
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/vmbp_datapath.sv =====
module vmbp_datapath
  import vmbp_pkg::*;
#(
  parameter int unsigned VRAM_WORDS         = 34816,
  parameter int unsigned PALETTE_BANK_WORDS = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  output dp_sts_t             sts,
  input  logic [3:0]          in_kind,
  input  logic [ADDR_W-1:0]   in_address,
  input  logic [DATA_W-1:0]   in_write_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [DATA_W-1:0]   out_read_data,
  output logic [COLOR_W-1:0]  out_red,
  output logic [COLOR_W-1:0]  out_green,
  output logic [COLOR_W-1:0]  out_blue
);

  localparam int unsigned VAW    = $clog2(VRAM_WORDS);
  localparam int unsigned PAW    = $clog2(PALETTE_BANK_WORDS);
  localparam int unsigned SW     = PAW + 1;
  localparam int unsigned QW     = ADDR_W - PAW + 1;
  localparam int unsigned RSHIFT = 25;
  // Reciprocal for index / PALETTE_BANK_WORDS, exact for 13-bit indexes
  localparam int unsigned RECIP  = ((1 << RSHIFT) + PALETTE_BANK_WORDS - 1) / PALETTE_BANK_WORDS;
  localparam int unsigned PW     = ADDR_W + 22;

  // Captured transaction
  kind_t               kind_r;
  logic                lane_r;
  logic [DATA_W-1:0]   data_r;
  logic [ADDR_W-1:0]   idx_r;
  logic [QW-1:0]       quot_r;

  // Architectural state
  logic [DATA_W-1:0]   ptr_r, ptr_nxt;
  logic                half_r, half_nxt;
  logic [DATA_W-1:0]   step_r, step_nxt;
  logic                bank_r, bank_nxt;
  logic                shadow_r, shadow_nxt;

  // Result register
  logic                out_valid_r;
  logic [DATA_W-1:0]   rd_r, rd_nxt;
  logic [COLOR_W-1:0]  red_r, red_nxt, green_r, green_nxt, blue_r, blue_nxt;

  logic [ADDR_W-1:0]   idx_in;
  logic [PW-1:0]       quot_prod;
  logic [ADDR_W-1:0]   base;
  logic [ADDR_W-1:0]   rem_full;
  logic [SW-1:0]       pal_addr;
  logic                pal_we;
  logic [DATA_W-1:0]   pal_wd, pal_q;
  logic                vram_in_range;
  logic                vram_we;
  logic [DATA_W-1:0]   vram_q;
  logic [DATA_W-1:0]   ptr_step;
  logic                dark;

  // Palette index: word index, or color index for a lookup
  assign idx_in    = (kind_t'(in_kind) == KIND_LOOKUP) ? in_address
                                                       : {1'b0, in_address[ADDR_W-1:1]};
  assign quot_prod = PW'(idx_in) * PW'(RECIP);

  // Capture on accept
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r <= kind_t'(in_kind);
      lane_r <= in_address[0];
      data_r <= in_write_data;
      idx_r  <= idx_in;
      quot_r <= QW'(quot_prod >> RSHIFT);
    end
  end

  // Palette slot: bank base plus index mod bank size
  assign base     = ADDR_W'({{(ADDR_W-QW){1'b0}}, quot_r} * ADDR_W'(PALETTE_BANK_WORDS));
  assign rem_full = idx_r - base;
  assign pal_addr = bank_r ? (SW'(PALETTE_BANK_WORDS) + {1'b0, rem_full[PAW-1:0]})
                           : {1'b0, rem_full[PAW-1:0]};

  assign pal_we = cmd.exec && (kind_r == KIND_PAL_WR || kind_r == KIND_PAL_BWR);

  // Word write or byte merge into the current entry
  always_comb begin
    if (kind_r == KIND_PAL_WR) begin
      pal_wd = data_r;
    end else if (lane_r) begin
      pal_wd = {pal_q[15:8], data_r[7:0]};
    end else begin
      pal_wd = {data_r[7:0], pal_q[7:0]};
    end
  end

  vmbp_ram #(
    .WIDTH (DATA_W),
    .DEPTH (2 * PALETTE_BANK_WORDS)
  ) u_pal_ram (
    .clk   (clk),
    .addr  (pal_addr),
    .we    (pal_we),
    .wdata (pal_wd),
    .rdata (pal_q)
  );

  // Video RAM at the pointer
  assign vram_in_range = ({1'b0, ptr_r} < 17'(VRAM_WORDS));
  assign vram_we       = cmd.exec && (kind_r == KIND_VRAM_WR) && vram_in_range;

  vmbp_ram #(
    .WIDTH (DATA_W),
    .DEPTH (VRAM_WORDS)
  ) u_vram (
    .clk   (clk),
    .addr  (ptr_r[VAW-1:0]),
    .we    (vram_we),
    .wdata (data_r),
    .rdata (vram_q)
  );

  assign ptr_step = ptr_r + step_r;
  assign dark     = ~pal_q[15];

  // Execute: state update and result
  always_comb begin
    ptr_nxt    = ptr_r;
    half_nxt   = half_r;
    step_nxt   = step_r;
    bank_nxt   = bank_r;
    shadow_nxt = shadow_r;
    rd_nxt     = '0;
    red_nxt    = '0;
    green_nxt  = '0;
    blue_nxt   = '0;
    case (kind_r)
      KIND_SET_ADDR: begin
        ptr_nxt  = data_r;
        half_nxt = data_r[15];
      end
      KIND_VRAM_RD: rd_nxt = vram_in_range ? vram_q : '0;
      KIND_VRAM_WR: ptr_nxt = {half_r, ptr_step[HALF_MASK-1:0]};
      KIND_SET_MOD: step_nxt = data_r;
      KIND_MOD_RD:  rd_nxt = step_r;
      KIND_PAL_RD:  rd_nxt = pal_q;
      KIND_PAL_BRD: rd_nxt = lane_r ? {8'h00, pal_q[7:0]} : {8'h00, pal_q[15:8]};
      KIND_PAL_WR:  ;
      KIND_PAL_BWR: ;
      KIND_BANK:    bank_nxt = data_r[0];
      KIND_SHADOW:  shadow_nxt = data_r[0];
      KIND_LOOKUP: begin
        red_nxt   = scale6({pal_q[11:8], pal_q[14], dark});
        green_nxt = scale6({pal_q[7:4], pal_q[13], dark});
        blue_nxt  = scale6({pal_q[3:0], pal_q[12], dark});
        if (shadow_r) begin
          red_nxt   = red_nxt >> 1;
          green_nxt = green_nxt >> 1;
          blue_nxt  = blue_nxt >> 1;
        end
      end
      default: ;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r    <= '0;
      half_r   <= 1'b0;
      step_r   <= '0;
      bank_r   <= 1'b0;
      shadow_r <= 1'b0;
    end else if (cmd.exec) begin
      ptr_r    <= ptr_nxt;
      half_r   <= half_nxt;
      step_r   <= step_nxt;
      bank_r   <= bank_nxt;
      shadow_r <= shadow_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rd_r    <= rd_nxt;
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign sts.out_stall = out_valid_r && !out_ready;
  assign out_valid     = out_valid_r;
  assign out_read_data = rd_r;
  assign out_red       = red_r;
  assign out_green     = green_r;
  assign out_blue      = blue_r;

endmodule

// ===== dv/video_memory_bus_port_unit_test.sv =====
module video_memory_bus_port_unit_test
  import vmbp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VRAM_WORDS     = 34816;
  localparam int unsigned PAL_BANK_WORDS = 4096;
  localparam int unsigned TARGET_ITEMS   = 1200;
  localparam int unsigned MAX_WAIT       = 18;
  localparam int unsigned STALL_LIMIT    = 2000;
  localparam int unsigned DRAIN_CYCLES   = 12;

  // kinds the block decodes as no-ops
  localparam logic [3:0] KIND_UNUSED_FIRST = 4'd12;
  localparam logic [3:0] KIND_UNUSED_LAST  = 4'd15;

  typedef struct packed {
    logic [3:0]        kind;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } bus_access_t;

  typedef struct packed {
    logic [DATA_W-1:0]  read_data;
    logic [COLOR_W-1:0] red, green, blue;
  } bus_reply_t;

  logic                clk           = 1'b0;
  logic                rst_n         = 1'b0;
  logic                in_valid      = 1'b0;
  logic                in_ready;
  logic [3:0]          in_kind       = '0;
  logic [ADDR_W-1:0]   in_address    = '0;
  logic [DATA_W-1:0]   in_write_data = '0;
  logic                out_valid;
  logic                out_ready     = 1'b0;
  logic [DATA_W-1:0]   out_read_data;
  logic [COLOR_W-1:0]  out_red;
  logic [COLOR_W-1:0]  out_green;
  logic [COLOR_W-1:0]  out_blue;

  video_memory_bus_port_unit #(
    .VRAM_WORDS        (VRAM_WORDS),
    .PALETTE_BANK_WORDS(PAL_BANK_WORDS)
  ) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_address   (in_address),
    .in_write_data(in_write_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_read_data(out_read_data),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Input transactions waiting to be driven, and result transactions still owed
  bus_access_t access_queue[$];
  bus_reply_t  awaited_replies[$];
  int unsigned errors = 0;

  // ---------------------------------------------------------------------
  // Shadow copy of the block's memories and registers
  // ---------------------------------------------------------------------
  logic [15:0] vram_mem [0:VRAM_WORDS-1];
  logic [15:0] pal_mem  [0:2*PAL_BANK_WORDS-1];
  logic [15:0] vram_ptr  = '0;
  logic [15:0] vram_step = '0;
  logic        pal_bank  = 1'b0;
  logic        shadow_on = 1'b0;

  // 6-bit color level widened to 8 bits
  function automatic logic [7:0] level_8bit(input logic [5:0] v);
    int unsigned p;
    p = v * 259 + 33;
    return 8'(p >> 6);
  endfunction

  // Apply one transaction to the shadow state and return the result it gives.
  // Bank size is 4096 words, so the slot is the bank bit over a 12-bit index.
  task automatic apply_bus_access(input bus_access_t t, output bus_reply_t rep);
    logic [12:0] slot;
    logic [15:0] w;
    logic        dark;
    rep  = '0;
    slot = {pal_bank, t.addr[12:1]};
    case (t.kind)
      KIND_SET_ADDR: vram_ptr = t.data;
      KIND_VRAM_RD: begin
        if (vram_ptr < VRAM_WORDS) rep.read_data = vram_mem[vram_ptr];
      end
      KIND_VRAM_WR: begin
        if (vram_ptr < VRAM_WORDS) vram_mem[vram_ptr] = t.data;
        // step stays inside the current 32K half
        vram_ptr = {vram_ptr[15], vram_ptr[14:0] + vram_step[14:0]};
      end
      KIND_SET_MOD: vram_step = t.data;
      KIND_MOD_RD:  rep.read_data = vram_step;
      KIND_PAL_RD:  rep.read_data = pal_mem[slot];
      KIND_PAL_BRD: begin
        w = pal_mem[slot];
        rep.read_data = t.addr[0] ? {8'h00, w[7:0]} : {8'h00, w[15:8]};
      end
      KIND_PAL_WR: pal_mem[slot] = t.data;
      KIND_PAL_BWR: begin
        w = pal_mem[slot];
        if (t.addr[0]) w[7:0] = t.data[7:0];
        else w[15:8] = t.data[7:0];
        pal_mem[slot] = w;
      end
      KIND_BANK:   pal_bank  = t.data[0];
      KIND_SHADOW: shadow_on = t.data[0];
      KIND_LOOKUP: begin
        // color index wraps within the active bank
        w    = pal_mem[{pal_bank, t.addr[11:0]}];
        dark = ~w[15];
        rep.red   = level_8bit({w[11:8], w[14], dark});
        rep.green = level_8bit({w[7:4],  w[13], dark});
        rep.blue  = level_8bit({w[3:0],  w[12], dark});
        if (shadow_on) begin
          rep.red   = rep.red   >> 1;
          rep.green = rep.green >> 1;
          rep.blue  = rep.blue  >> 1;
        end
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Stimulus planning: tracks pointer, bank and written entries so that
  // no read ever touches memory that was never written
  // ---------------------------------------------------------------------
  logic [15:0] plan_ptr  = '0;
  logic [15:0] plan_step = '0;
  logic        plan_bank = 1'b0;
  int unsigned vram_written[$];
  logic [11:0] pal_written0[$];
  logic [11:0] pal_written1[$];

  task automatic queue_access(input logic [3:0] k, input logic [12:0] a,
                              input logic [15:0] d);
    bus_access_t t;
    t.kind = k;
    t.addr = a;
    t.data = d;
    access_queue.push_back(t);
    case (k)
      KIND_SET_ADDR: plan_ptr = d;
      KIND_SET_MOD:  plan_step = d;
      KIND_BANK:     plan_bank = d[0];
      KIND_VRAM_WR: begin
        if (plan_ptr < VRAM_WORDS) vram_written.push_back(32'(plan_ptr));
        plan_ptr = {plan_ptr[15], plan_ptr[14:0] + plan_step[14:0]};
      end
      KIND_PAL_WR: begin
        if (plan_bank) pal_written1.push_back(a[12:1]);
        else pal_written0.push_back(a[12:1]);
      end
      default: ;
    endcase
  endtask

  // Pick a palette word of the active bank that holds known data
  task automatic pick_pal_word(output bit found, output logic [11:0] w);
    w = '0;
    if (plan_bank) begin
      found = pal_written1.size() != 0;
      if (found) w = pal_written1[$urandom_range(0, pal_written1.size() - 1)];
    end else begin
      found = pal_written0.size() != 0;
      if (found) w = pal_written0[$urandom_range(0, pal_written0.size() - 1)];
    end
  endtask

  function automatic int unsigned draw_wait(input bit steady);
    return steady ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // ---------------------------------------------------------------------
  // Input driver
  // ---------------------------------------------------------------------
  bus_access_t driven_access;
  bus_reply_t  predicted;
  int unsigned in_gap    = 0;
  bit          in_steady = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        apply_bus_access(driven_access, predicted);
        awaited_replies.push_back(predicted);
      end
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (access_queue.size() != 0) begin
        driven_access = access_queue.pop_front();
        in_kind       <= driven_access.kind;
        in_address    <= driven_access.addr;
        in_write_data <= driven_access.data;
        in_valid      <= 1'b1;
        if ($urandom_range(0, 39) == 0) in_steady = !in_steady;
        in_gap = draw_wait(in_steady);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output monitor and checker
  // ---------------------------------------------------------------------
  int unsigned out_gap    = 0;
  bit          out_steady = 1'b0;

  always @(posedge clk) begin
    bus_reply_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_replies.size() == 0) begin
          $display("%0t unexpected transaction: read_data %h rgb %h %h %h", $time,
                   out_read_data, out_red, out_green, out_blue);
          errors++;
        end else begin
          want = awaited_replies.pop_front();
          if (out_read_data !== want.read_data) begin
            $display("%0t read_data: expected %h, got %h", $time, want.read_data,
                     out_read_data);
            errors++;
          end
          if (out_red !== want.red) begin
            $display("%0t red: expected %h, got %h", $time, want.red, out_red);
            errors++;
          end
          if (out_green !== want.green) begin
            $display("%0t green: expected %h, got %h", $time, want.green, out_green);
            errors++;
          end
          if (out_blue !== want.blue) begin
            $display("%0t blue: expected %h, got %h", $time, want.blue, out_blue);
            errors++;
          end
        end
        if ($urandom_range(0, 39) == 0) out_steady = !out_steady;
        out_gap = draw_wait(out_steady);
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: no transaction on either channel for too long
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("%0t no progress for %0d cycles", $time, STALL_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------
  initial begin
    int unsigned sel;
    bit          found;
    logic [11:0] w;
    logic [15:0] a;

    // Directed: palette extremes, byte lanes, index wrap, shadow, bank
    queue_access(KIND_PAL_WR,  13'h0000, 16'hFFFF);
    queue_access(KIND_PAL_WR,  13'h1FFE, 16'h0000);
    queue_access(KIND_PAL_WR,  13'h0A43, 16'h8000);
    queue_access(KIND_PAL_RD,  13'h0000, 16'h0000);
    queue_access(KIND_PAL_BRD, 13'h0001, 16'hFFFF);
    queue_access(KIND_PAL_BWR, 13'h1FFF, 16'hFFAB);
    queue_access(KIND_PAL_BWR, 13'h1FFE, 16'h0012);
    queue_access(KIND_PAL_BRD, 13'h1FFE, 16'h0000);
    queue_access(KIND_LOOKUP,  13'h0000, 16'h0000);
    queue_access(KIND_LOOKUP,  13'h1FFF, 16'hFFFF);
    queue_access(KIND_SHADOW,  13'h1FFF, 16'hFFFF);
    queue_access(KIND_LOOKUP,  13'h1521, 16'h0000);
    queue_access(KIND_SHADOW,  13'h0000, 16'hFFFE);
    queue_access(KIND_BANK,    13'h0000, 16'h0001);
    queue_access(KIND_PAL_WR,  13'h0000, 16'h1234);
    queue_access(KIND_PAL_RD,  13'h0001, 16'h0000);
    queue_access(KIND_BANK,    13'h1FFF, 16'hFFFE);
    // Directed: negative step, writes beyond the VRAM size, pointer held on read
    queue_access(KIND_SET_MOD,  13'h0000, 16'hFFFF);
    queue_access(KIND_MOD_RD,   13'h1FFF, 16'h0000);
    queue_access(KIND_SET_ADDR, 13'h0000, 16'h8800);
    queue_access(KIND_VRAM_WR,  13'h0000, 16'h0000);
    queue_access(KIND_VRAM_WR,  13'h1FFF, 16'hFFFF);
    queue_access(KIND_SET_ADDR, 13'h0000, 16'h87FF);
    queue_access(KIND_VRAM_RD,  13'h0000, 16'h0000);
    queue_access(KIND_VRAM_RD,  13'h1FFF, 16'hFFFF);
    queue_access(KIND_SET_ADDR, 13'h0000, 16'hFFFF);
    queue_access(KIND_VRAM_RD,  13'h0000, 16'h0000);
    queue_access(KIND_UNUSED_LAST, 13'h1FFF, 16'hFFFF);

    // Random: mostly write-then-read sequences with random content
    while (access_queue.size() < TARGET_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 20) begin
        // VRAM write burst from a random start or one near the interesting boundaries
        case ($urandom_range(0, 3))
          0: a = 16'($urandom);
          1: a = 16'($urandom_range(0, 1) * 32768 + 32752 + $urandom_range(0, 15));
          2: a = 16'($urandom_range(VRAM_WORDS - 16, VRAM_WORDS + 15));
          default: a = 16'($urandom_range(0, 1) * 32768 + $urandom_range(0, 63));
        endcase
        queue_access(KIND_SET_ADDR, 13'($urandom), a);
        if ($urandom_range(0, 1) == 0) begin
          case ($urandom_range(0, 3))
            0: a = 16'd1;
            1: a = 16'($urandom_range(0, 16) - 8);
            2: a = 16'($urandom);
            default: a = 16'd0;
          endcase
          queue_access(KIND_SET_MOD, 13'($urandom), a);
        end
        repeat ($urandom_range(1, 8))
          queue_access(KIND_VRAM_WR, 13'($urandom), 16'($urandom));
      end else if (sel < 40) begin
        // VRAM read-back of written words, now and then beyond the size
        repeat ($urandom_range(1, 4)) begin
          if (vram_written.size() == 0 || $urandom_range(0, 4) == 0)
            a = 16'($urandom_range(VRAM_WORDS, 65535));
          else
            a = 16'(vram_written[$urandom_range(0, vram_written.size() - 1)]);
          queue_access(KIND_SET_ADDR, 13'($urandom), a);
          repeat ($urandom_range(1, 2))
            queue_access(KIND_VRAM_RD, 13'($urandom), 16'($urandom));
        end
      end else if (sel < 45) begin
        if ($urandom_range(0, 1) == 0)
          queue_access(KIND_SET_MOD, 13'($urandom), 16'($urandom));
        queue_access(KIND_MOD_RD, 13'($urandom), 16'($urandom));
      end else if (sel < 60) begin
        repeat ($urandom_range(1, 4))
          queue_access(KIND_PAL_WR, 13'($urandom), 16'($urandom));
      end else if (sel < 70) begin
        // byte write merges into a known word
        pick_pal_word(found, w);
        if (found) begin
          queue_access(KIND_PAL_BWR, {w, 1'($urandom)}, 16'($urandom));
          if ($urandom_range(0, 1) == 0)
            queue_access(KIND_PAL_BRD, {w, 1'($urandom)}, 16'($urandom));
        end else begin
          queue_access(KIND_PAL_WR, 13'($urandom), 16'($urandom));
        end
      end else if (sel < 80) begin
        pick_pal_word(found, w);
        if (!found)
          queue_access(KIND_PAL_WR, 13'($urandom), 16'($urandom));
        else if ($urandom_range(0, 1) == 0)
          queue_access(KIND_PAL_RD, {w, 1'($urandom)}, 16'($urandom));
        else
          queue_access(KIND_PAL_BRD, {w, 1'($urandom)}, 16'($urandom));
      end else if (sel < 93) begin
        // color lookups; top index bit exercises the wrap
        repeat ($urandom_range(1, 6)) begin
          pick_pal_word(found, w);
          if (found) queue_access(KIND_LOOKUP, {1'($urandom), w}, 16'($urandom));
          else queue_access(KIND_PAL_WR, 13'($urandom), 16'($urandom));
        end
      end else if (sel < 97) begin
        if ($urandom_range(0, 1) == 0)
          queue_access(KIND_BANK, 13'($urandom), 16'($urandom));
        else
          queue_access(KIND_SHADOW, 13'($urandom), 16'($urandom));
      end else begin
        queue_access(4'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST)),
                     13'($urandom), 16'($urandom));
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (access_queue.size() != 0 || in_valid || awaited_replies.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && awaited_replies.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
